// ===== src/pbr_nt_pkg.sv =====
// Shared constants and types of the neutral tone mapper.
// No dependencies; all other files but pbr_nt_div import it.
`timescale 1ns / 1ps

package pbr_nt_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int INT_BITS_DEF  = 8;

	// Offset channels are held as unsigned values up to 2^38 - 1.
	localparam int HOLD_BITS = 38;

	// Square argument limit and the width that holds it.
	localparam longint SQ_LIM      = 64'sd2147483648;
	localparam int     SQ_CAP_BITS = 32;

	typedef logic [HOLD_BITS-1:0] hold_t;

	// Carried alongside the peak compression divider.
	typedef struct packed {
		hold_t [2:0] c;
		hold_t       peak;
		logic        byp;
	} d1_side_t;

	// Carried alongside the ratio divider.
	typedef struct packed {
		hold_t [2:0] c;
		logic        byp;
	} d2_side_t;

endpackage

// ===== src/pbr_nt_if.sv =====
// Pixel stream interfaces: valid/ready handshake with RGB payload.
// Depends on pbr_nt_pkg for the default channel width.
`timescale 1ns / 1ps

interface pbr_nt_in_if import pbr_nt_pkg::*; #(
	parameter int W = INT_BITS_DEF + FRAC_BITS_DEF
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] red_in;
	logic signed [W-1:0] green_in;
	logic signed [W-1:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in, input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface pbr_nt_out_if import pbr_nt_pkg::*; #(
	parameter int W = INT_BITS_DEF + FRAC_BITS_DEF
) ();
	logic                valid;
	logic                ready;
	logic signed [W-1:0] red_out;
	logic signed [W-1:0] green_out;
	logic signed [W-1:0] blue_out;

	modport source (output valid, output red_out, output green_out, output blue_out, input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out, output ready);
endinterface

// ===== src/pbr_nt_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// Stand-alone; the quotient must fit in QW bits.
`timescale 1ns / 1ps

module pbr_nt_div #(
	parameter int NW = 32,
	parameter int DW = 32,
	parameter int QW = 16,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_v,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	input  logic [SW-1:0] side,
	output logic          out_v,
	output logic [QW-1:0] quo,
	output logic [SW-1:0] side_o
);
	logic [DW-1:0] rem_s [QW+1];
	logic [QW-1:0] lo_s  [QW+1];
	logic [DW-1:0] dv_s  [QW+1];
	logic [SW-1:0] sd_s  [QW+1];
	logic          v_s   [QW+1];

	assign rem_s[0] = DW'(dividend >> QW);
	assign lo_s[0]  = dividend[QW-1:0];
	assign dv_s[0]  = divisor;
	assign sd_s[0]  = side;
	assign v_s[0]   = in_v;

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW:0] trial;
		logic        ge;

		always_comb begin
			trial = {rem_s[k], lo_s[k][QW-1]};
			ge    = trial >= {1'b0, dv_s[k]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? DW'(trial - {1'b0, dv_s[k]}) : DW'(trial);
				lo_s[k+1]  <= {lo_s[k][QW-2:0], ge};
				dv_s[k+1]  <= dv_s[k];
				sd_s[k+1]  <= sd_s[k];
			end
		end
	end

	assign out_v  = v_s[QW];
	assign quo    = lo_s[QW];
	assign side_o = sd_s[QW];

endmodule

// ===== src/pbr_nt_lane.sv =====
// One colour lane: scale by peak ratio, blend to new peak (or bypass), saturate.
// Depends on pbr_nt_pkg for the held channel type.
`timescale 1ns / 1ps

module pbr_nt_lane import pbr_nt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int W         = INT_BITS_DEF + FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  en,
	input  hold_t                 c,
	input  logic [FRAC_BITS:0]    ratio,
	input  logic [FRAC_BITS:0]    newp,
	input  logic signed [FRAC_BITS+1:0] g,
	input  logic                  byp,
	output logic signed [W-1:0]   y
);
	localparam int HW = HOLD_BITS;
	localparam int PW = HW + FRAC_BITS + 5;
	localparam longint HI = (longint'(1) << (W - 1)) - 1;
	localparam longint LO = -HI - 1;

	logic [HW+FRAC_BITS:0]   sp;
	logic [HW+1:0]           s_l1;
	logic [FRAC_BITS:0]      newp_l1;
	logic signed [FRAC_BITS+1:0] g_l1;
	logic                    byp_l1;
	hold_t                   c_l1;

	logic signed [HW+2:0]    diff;
	logic signed [PW-1:0]    pr_l2;
	logic [HW+1:0]           s_l2;
	logic                    byp_l2;
	hold_t                   c_l2;

	logic signed [HW+6:0]    ys;
	logic signed [HW+6:0]    pick;

	assign sp   = (HW+FRAC_BITS+1)'(c) * (HW+FRAC_BITS+1)'(ratio);
	assign diff = (HW+3)'(newp_l1) - (HW+3)'(s_l1);

	always_ff @(posedge clk) begin
		if (en) begin
			s_l1    <= (HW+2)'(sp >> FRAC_BITS);
			newp_l1 <= newp;
			g_l1    <= g;
			byp_l1  <= byp;
			c_l1    <= c;
			pr_l2   <= PW'(diff) * PW'(g_l1);
			s_l2    <= s_l1;
			byp_l2  <= byp_l1;
			c_l2    <= c_l1;
		end
	end

	always_comb begin
		ys   = (HW+7)'(pr_l2 >>> FRAC_BITS) + (HW+7)'(s_l2);
		pick = byp_l2 ? (HW+7)'(c_l2) : ys;
		if (longint'(pick) > HI) begin
			y = W'(HI);
		end else if (longint'(pick) < LO) begin
			y = W'(LO);
		end else begin
			y = W'(pick);
		end
	end

endmodule

// ===== src/pbr_neutral_tone_map_core.sv =====
// Neutral tone mapper for linear HDR RGB pixels in signed fixed point
// (INT_BITS.FRAC_BITS, Q8.16 by default). One pixel enters per clock and
// the result passes a register for the minimum and square, one for the
// offset, clamp and peak, a FRAC_BITS-stage divider for the compressed
// peak, a register for the desaturation term, two FRAC_BITS+1 stage
// dividers side by side for the scale ratio and the blend weight, the
// registers of the three colour lanes and the output register. The
// dividers give one quotient bit per stage, which sets the latency; the
// whole pipe holds only while the output register is full and not taken.
// Depends on pbr_nt_pkg, pbr_nt_if, pbr_nt_div and pbr_nt_lane.
`timescale 1ns / 1ps

module pbr_neutral_tone_map_core import pbr_nt_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int INT_BITS  = INT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	pbr_nt_in_if.sink      pixel,
	pbr_nt_out_if.source   mapped
);
	localparam int W  = INT_BITS + FRAC_BITS;
	localparam int F  = FRAC_BITS;
	localparam int HW = HOLD_BITS;
	localparam int MW = (W > SQ_CAP_BITS) ? SQ_CAP_BITS : W;
	localparam int OW = 2 * MW - FRAC_BITS + 6;

	localparam longint ONE      = longint'(1) << FRAC_BITS;
	localparam longint START_C  = ((longint'(76) << FRAC_BITS) + 50) / 100;
	localparam longint KNEE     = ONE - START_C;
	localparam longint DARK_T   = ((longint'(8) << FRAC_BITS) + 50) / 100;
	localparam longint FLAT_OFS = ((longint'(4) << FRAC_BITS) + 50) / 100;
	localparam longint DESAT    = ((longint'(15) << FRAC_BITS) + 50) / 100;
	localparam longint HOLD_MAX = (longint'(1) << HOLD_BITS) - 1;

	logic en;

	// Minimum and square
	logic signed [W-1:0] cin [3];
	logic signed [W-1:0] xmin;
	logic [W-1:0]        mag;
	logic [MW-1:0]       mcap;

	logic signed [W-1:0] c_s1 [3];
	logic signed [W-1:0] x_s1;
	logic                dark_s1;
	logic [2*MW-1:0]     sq_s1;
	logic                v_s1;

	// Offset, clamp and peak
	logic [OW-1:0]        qv;
	logic signed [OW-1:0] ofs;
	logic signed [OW:0]   dv [3];
	hold_t                hv [3];
	hold_t                pk;

	hold_t    c_s2 [3];
	hold_t    peak_s2;
	logic     byp_s2;
	logic     v_s2;
	d1_side_t sd1_in;
	d1_side_t sd1_out;
	logic [$bits(d1_side_t)-1:0] sd1_vec;
	logic [F-1:0] q1;
	logic         v_d1;

	// Desaturation term
	logic [F:0]               newp;
	logic signed [HW+1:0]     pd;
	logic signed [HW+F+2:0]   tp;
	logic signed [HW+F+2:0]   tt;

	logic [F:0]    newp_s3;
	logic [HW+1:0] t_s3;
	hold_t         peak_s3;
	hold_t         c_s3 [3];
	logic          byp_s3;
	logic          v_s3;

	d2_side_t sd2_in;
	d2_side_t sd2_out;
	logic [$bits(d2_side_t)-1:0] sd2_vec;
	logic [F:0] q2;
	logic [F:0] q3;
	logic [F:0] newp_d;
	logic       v_d2;
	logic       v_d3;
	logic signed [F+1:0] gw;

	logic                v_l1;
	logic                v_l2;
	logic signed [W-1:0] y [3];

	logic                out_v_q;
	logic signed [W-1:0] red_q;
	logic signed [W-1:0] green_q;
	logic signed [W-1:0] blue_q;

	assign en          = !out_v_q || mapped.ready;
	assign pixel.ready = en;

	assign cin[0] = pixel.red_in;
	assign cin[1] = pixel.green_in;
	assign cin[2] = pixel.blue_in;

	always_comb begin
		xmin = cin[0];
		if (cin[1] < xmin) begin
			xmin = cin[1];
		end
		if (cin[2] < xmin) begin
			xmin = cin[2];
		end
		mag  = xmin[W-1] ? (~$unsigned(xmin) + W'(1)) : $unsigned(xmin);
		mcap = (64'(mag) > SQ_LIM) ? MW'(SQ_LIM) : MW'(mag);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_l1 <= 1'b0;
			v_l2 <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s1 <= pixel.valid;
			v_s2 <= v_s1;
			v_s3 <= v_d1;
			v_l1 <= v_d2 && v_d3;
			v_l2 <= v_l1;
			out_v_q <= v_l2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1    <= cin;
			x_s1    <= xmin;
			dark_s1 <= longint'(xmin) < DARK_T;
			sq_s1   <= (2*MW)'(mcap) * (2*MW)'(mcap);
		end
	end

	always_comb begin
		qv  = OW'((OW'(sq_s1 >> F) * OW'(25)) >> 2);
		ofs = dark_s1 ? (OW'(x_s1) - $signed(qv)) : OW'(FLAT_OFS);
		for (int i = 0; i < 3; i++) begin
			dv[i] = (OW+1)'(c_s1[i]) - (OW+1)'(ofs);
			if (dv[i] < 0) begin
				hv[i] = '0;
			end else if (longint'(dv[i]) > HOLD_MAX) begin
				hv[i] = HW'(HOLD_MAX);
			end else begin
				hv[i] = HW'(dv[i]);
			end
		end
		pk = hv[0];
		if (hv[1] > pk) begin
			pk = hv[1];
		end
		if (hv[2] > pk) begin
			pk = hv[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s2    <= hv;
			peak_s2 <= pk;
			byp_s2  <= 64'(pk) < START_C;
		end
	end

	always_comb begin
		sd1_in.c[0] = c_s2[0];
		sd1_in.c[1] = c_s2[1];
		sd1_in.c[2] = c_s2[2];
		sd1_in.peak = peak_s2;
		sd1_in.byp  = byp_s2;
	end

	pbr_nt_div #(
		.NW(2 * F),
		.DW(HW),
		.QW(F),
		.SW($bits(d1_side_t))
	) u_div_peak (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s2),
		.dividend ((2*F)'(KNEE * KNEE)),
		.divisor  (peak_s2 - HW'(START_C - KNEE)),
		.side     (sd1_in),
		.out_v    (v_d1),
		.quo      (q1),
		.side_o   (sd1_vec)
	);

	assign sd1_out = d1_side_t'(sd1_vec);

	always_comb begin
		newp = (F+1)'(ONE) - (F+1)'(q1);
		pd   = (HW+2)'(sd1_out.peak) - (HW+2)'(newp);
		tp   = (HW+F+3)'(pd) * (HW+F+3)'(DESAT);
		tt   = (tp >>> F) + (HW+F+3)'(ONE);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			newp_s3 <= newp;
			t_s3    <= (HW+2)'(tt);
			peak_s3 <= sd1_out.peak;
			c_s3[0] <= sd1_out.c[0];
			c_s3[1] <= sd1_out.c[1];
			c_s3[2] <= sd1_out.c[2];
			byp_s3  <= sd1_out.byp;
		end
	end

	always_comb begin
		sd2_in.c[0] = c_s3[0];
		sd2_in.c[1] = c_s3[1];
		sd2_in.c[2] = c_s3[2];
		sd2_in.byp  = byp_s3;
	end

	pbr_nt_div #(
		.NW(2 * F + 1),
		.DW(HW),
		.QW(F + 1),
		.SW($bits(d2_side_t))
	) u_div_ratio (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s3),
		.dividend ((2*F+1)'(newp_s3) << F),
		.divisor  (peak_s3),
		.side     (sd2_in),
		.out_v    (v_d2),
		.quo      (q2),
		.side_o   (sd2_vec)
	);

	pbr_nt_div #(
		.NW(2 * F + 1),
		.DW(HW + 2),
		.QW(F + 1),
		.SW(F + 1)
	) u_div_blend (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_v     (v_s3),
		.dividend ((2*F+1)'(1) << (2 * F)),
		.divisor  (t_s3),
		.side     (newp_s3),
		.out_v    (v_d3),
		.quo      (q3),
		.side_o   (newp_d)
	);

	assign sd2_out = d2_side_t'(sd2_vec);
	assign gw      = (F+2)'(ONE) - (F+2)'(q3);

	for (genvar i = 0; i < 3; i++) begin : g_lane
		pbr_nt_lane #(
			.FRAC_BITS(F),
			.W(W)
		) u_lane (
			.clk   (clk),
			.en    (en),
			.c     (sd2_out.c[i]),
			.ratio (q2),
			.newp  (newp_d),
			.g     (gw),
			.byp   (sd2_out.byp),
			.y     (y[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			red_q   <= y[0];
			green_q <= y[1];
			blue_q  <= y[2];
		end
	end

	assign mapped.valid     = out_v_q;
	assign mapped.red_out   = red_q;
	assign mapped.green_out = green_q;
	assign mapped.blue_out  = blue_q;

endmodule

// ===== sim/pbr_neutral_tone_map_core_tb.sv =====
// Testbench for the neutral tone mapper core: directed and random pixels.
// Uses the core, pbr_nt_pkg, pbr_nt_if; results are checked against a local predictor.
`timescale 1ns / 1ps

module pbr_neutral_tone_map_core_tb;
	import pbr_nt_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam int W = INT_BITS_DEF + FRAC_BITS_DEF;
	localparam longint ONE_K = 64'sd1 << FB;
	localparam longint START_K = ((64'sd76 << FB) + 50) / 100;
	localparam longint KNEE_K = ONE_K - START_K;
	localparam longint DARK_K = ((64'sd8 << FB) + 50) / 100;
	localparam longint FLAT_K = ((64'sd4 << FB) + 50) / 100;
	localparam longint DESAT_K = ((64'sd15 << FB) + 50) / 100;
	localparam longint HOLD_K = (64'sd1 << 38) - 1;
	localparam int LATENCY = 2 * FB + 7;
	localparam longint LIMIT = 400000;

	typedef struct packed {
		logic signed [W-1:0] r;
		logic signed [W-1:0] g;
		logic signed [W-1:0] b;
	} pix_t;

	logic clk;
	logic arst_n;
	pbr_nt_in_if #(.W(W)) pixel ();
	pbr_nt_out_if #(.W(W)) mapped ();

	pbr_neutral_tone_map_core dut (.clk(clk), .arst_n(arst_n), .pixel(pixel), .mapped(mapped));

	pix_t mapped_q[$];
	int errors = 0;
	int n_sent = 0;
	int n_got = 0;
	longint cycles = 0;
	int src_idle_pct = 35;
	int snk_idle_pct = 35;
	int hold_cycles = 0;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint floor_shr(longint v, int s);
		return v >>> s;
	endfunction

	function automatic logic signed [W-1:0] clamp_w(longint v);
		longint hi, lo;
		hi = (64'sd1 <<< (W - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) v = hi;
		if (v < lo) v = lo;
		return v[W-1:0];
	endfunction

	function automatic pix_t tone_map(pix_t p);
		longint c[3];
		longint x, ofs, peak, np, ratio, t, gw, m, sq, s;
		pix_t o;
		c[0] = p.r;
		c[1] = p.g;
		c[2] = p.b;
		x = c[0];
		if (c[1] < x) x = c[1];
		if (c[2] < x) x = c[2];
		if (x < DARK_K) begin
			m = (x < 0) ? -x : x;
			if (m > 64'sd2147483648) m = 64'sd2147483648;
			sq = longint'(64'(unsigned'(m) * unsigned'(m)) >> FB);
			ofs = x - ((sq * 25) >>> 2);
		end else begin
			ofs = FLAT_K;
		end
		for (int i = 0; i < 3; i++) begin
			c[i] = c[i] - ofs;
			if (c[i] > HOLD_K) c[i] = HOLD_K;
			if (c[i] < 0) c[i] = 0;
		end
		peak = c[0];
		if (c[1] > peak) peak = c[1];
		if (c[2] > peak) peak = c[2];
		if (peak < START_K) begin
			o.r = clamp_w(c[0]);
			o.g = clamp_w(c[1]);
			o.b = clamp_w(c[2]);
			return o;
		end
		np = ONE_K - (KNEE_K * KNEE_K) / (peak + KNEE_K - START_K);
		ratio = (np * ONE_K) / peak;
		t = floor_shr(DESAT_K * (peak - np), FB) + ONE_K;
		gw = ONE_K - (ONE_K * ONE_K) / t;
		for (int i = 0; i < 3; i++) begin
			s = (c[i] * ratio) >>> FB;
			c[i] = s + floor_shr((np - s) * gw, FB);
		end
		o.r = clamp_w(c[0]);
		o.g = clamp_w(c[1]);
		o.b = clamp_w(c[2]);
		return o;
	endfunction

	// Sink side: random stalls, plus an optional long hold-off.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mapped.ready <= 1'b0;
		end else if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			mapped.ready <= 1'b0;
		end else begin
			mapped.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	always @(posedge clk) begin
		pix_t e;
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
		if (arst_n && mapped.valid && mapped.ready) begin
			n_got <= n_got + 1;
			if (mapped_q.size() == 0) begin
				$error("unexpected transfer r=%0d g=%0d b=%0d",
					mapped.red_out, mapped.green_out, mapped.blue_out);
				errors++;
			end else begin
				e = mapped_q.pop_front();
				if (mapped.red_out !== e.r) begin
					$error("red_out expected %0d actual %0d", e.r, mapped.red_out);
					errors++;
				end
				if (mapped.green_out !== e.g) begin
					$error("green_out expected %0d actual %0d", e.g, mapped.green_out);
					errors++;
				end
				if (mapped.blue_out !== e.b) begin
					$error("blue_out expected %0d actual %0d", e.b, mapped.blue_out);
					errors++;
				end
			end
		end
	end

	task automatic send_pixel(pix_t p);
		while ($urandom_range(99) < src_idle_pct) begin
			pixel.valid <= 1'b0;
			@(negedge clk);
		end
		pixel.valid <= 1'b1;
		pixel.red_in <= p.r;
		pixel.green_in <= p.g;
		pixel.blue_in <= p.b;
		@(posedge clk);
		while (!pixel.ready) @(posedge clk);
		mapped_q.push_back(tone_map(p));
		n_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		pixel.valid <= 1'b0;
		while (mapped_q.size() != 0) @(negedge clk);
	endtask

	function automatic logic signed [W-1:0] rand_chan();
		int k;
		k = $urandom_range(9);
		if (k < 3) return W'($urandom);
		if (k < 6) return W'($urandom_range(32'(ONE_K * 4)));
		if (k < 8) return W'($urandom_range(32'(ONE_K / 4)));
		return W'($urandom_range(32'(ONE_K / 2))) - W'(ONE_K / 4);
	endfunction

	task automatic test_directed();
		logic signed [W-1:0] v[10];
		v = '{{1'b1, {(W-1){1'b0}}}, {1'b0, {(W-1){1'b1}}}, W'(0), W'(-1),
			W'(DARK_K - 1), W'(DARK_K), W'(START_K), W'(START_K + FLAT_K),
			W'(ONE_K), W'(ONE_K * 16)};
		foreach (v[i]) send_pixel('{v[i], v[i], v[i]});
		send_pixel('{v[1], v[2], v[0]});
		send_pixel('{v[7], v[5], v[4]});
		send_pixel('{v[8], v[2], v[9]});
		send_pixel('{W'(START_K + FLAT_K - 1), W'(FLAT_K), W'(FLAT_K)});
		send_pixel('{W'(ONE_K / 2), W'(ONE_K / 3), W'(ONE_K / 5)});
		send_pixel('{v[3], v[9], v[6]});
		send_pixel('{W'(ONE_K * 100), W'(ONE_K * 2), v[2]});
		send_pixel('{v[0], v[0], v[1]});
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++)
			send_pixel('{rand_chan(), rand_chan(), rand_chan()});
	endtask

	task automatic test_back_pressure();
		hold_cycles = 200;
		src_idle_pct = 0;
		test_random(150);
		src_idle_pct = 35;
		drain();
	endtask

	task automatic test_streaming();
		src_idle_pct = 0;
		snk_idle_pct = 0;
		test_random(300);
		src_idle_pct = 35;
		snk_idle_pct = 35;
	endtask

	initial begin
		arst_n = 1'b0;
		pixel.valid = 1'b0;
		pixel.red_in = '0;
		pixel.green_in = '0;
		pixel.blue_in = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		drain();
		test_random(250);
		test_back_pressure();
		test_streaming();
		test_random(300);
		drain();
		repeat (LATENCY + 10) @(negedge clk);
		$display("Sent %0d pixels, checked %0d results, including stalls and a long hold-off.",
			n_sent, n_got);
		if (errors == 0 && mapped_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule

// ===== files.f =====
src/pbr_nt_pkg.sv
src/pbr_nt_if.sv
src/pbr_nt_div.sv
src/pbr_nt_lane.sv
src/pbr_neutral_tone_map_core.sv
sim/pbr_neutral_tone_map_core_tb.sv
